// File: design/ccl_pkg.sv
// ----------------------------------------------------------------------------
// Console command lexer package
// Shared constants, codes and the event record passed from front to back.
// ----------------------------------------------------------------------------
package ccl_pkg;

  localparam int unsigned MaxTokensDefault  = 16;
  localparam int unsigned BucketBitsDefault = 12;
  localparam int unsigned QueueDepth        = 4;

  localparam logic [31:0] HashSeed        = 32'd5381;
  localparam logic [4:0]  TokenLimitReset = 5'd16;
  localparam logic [11:0] BucketMaskReset = 12'd255;

  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChSpace   = 8'h20;

  typedef enum logic [1:0] {
    SCAN_BETWEEN = 2'd0,
    SCAN_PLAIN   = 2'd1,
    SCAN_QUOTED  = 2'd2,
    SCAN_IGNORE  = 2'd3
  } scan_e;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_TOK_END = 2'd1,
    KIND_CMD_END = 2'd2
  } kind_e;

  typedef enum logic {
    CFG_TOKEN_LIMIT = 1'b0,
    CFG_BUCKET_MASK = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic        has_byte;
    logic        has_tok_end;
    logic        has_cmd_end;
    logic [7:0]  text;
    logic [3:0]  tok_num;
    logic [31:0] hash;
    logic [11:0] bucket;
    logic [4:0]  count;
  } ccl_event_t;

endpackage

// File: design/ccl_front.sv
// ----------------------------------------------------------------------------
// Console command lexer front end
// Classifies each byte, tracks scan state, token count and djb2 hash, and
// forms one event record per byte that yields results.
// ----------------------------------------------------------------------------
module ccl_front import ccl_pkg::*; #(
  parameter int unsigned MAX_TOKENS  = MaxTokensDefault,
  parameter int unsigned BUCKET_BITS = BucketBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  text_byte_i,
  input  logic [4:0]  token_limit_i,
  input  logic [11:0] bucket_mask_i,
  output ccl_event_t  ev_o,
  output logic        ev_valid_o
);

  localparam int unsigned TW = $clog2(MAX_TOKENS + 1);
  localparam int unsigned CW = (TW > 5) ? TW : 5;
  localparam logic [11:0] BktLowMask =
    (BUCKET_BITS >= 12) ? 12'hFFF : 12'((32'd1 << BUCKET_BITS) - 32'd1);
  localparam logic [CW-1:0] MaxTokensC = CW'(MAX_TOKENS);

  scan_e          scan_q, scan_d;
  logic           start_q, start_d;
  logic [TW-1:0]  tokens_q, tokens_d;
  logic [31:0]    hash_q, hash_d;

  logic           is_term, is_sep, is_quote, is_lead_slash, in_tok;
  logic [CW-1:0]  tok_ext, tl_ext, lim, tok_after;
  logic           lim_hit;
  logic           do_byte, do_finish, do_seed, do_cmd;
  logic [31:0]    hash_base, hash_step;

  assign is_term  = (text_byte_i == ChNul) || (text_byte_i == ChNewline) ||
                    (text_byte_i == ChSemi);
  assign is_sep   = (text_byte_i <= ChSpace);
  assign is_quote = (text_byte_i == ChQuote);
  assign is_lead_slash = start_q && (text_byte_i == ChSlash);
  assign in_tok   = (scan_q == SCAN_PLAIN) || (scan_q == SCAN_QUOTED);

  assign tok_ext  = CW'(tokens_q);
  assign tl_ext   = CW'(token_limit_i);
  assign lim      = (tl_ext > MaxTokensC) ? MaxTokensC : tl_ext;
  assign lim_hit  = (tok_ext >= lim);

  // next state
  always_comb begin
    scan_d = scan_q;
    if (accept_i) begin
      if (is_term) begin
        scan_d = SCAN_BETWEEN;
      end else if (!is_lead_slash) begin
        unique case (scan_q)
          SCAN_QUOTED: begin
            if (is_quote) scan_d = SCAN_BETWEEN;
          end
          SCAN_PLAIN: begin
            if (is_sep) scan_d = SCAN_BETWEEN;
          end
          SCAN_BETWEEN: begin
            if (!is_sep) begin
              if (lim_hit)       scan_d = SCAN_IGNORE;
              else if (is_quote) scan_d = SCAN_QUOTED;
              else               scan_d = SCAN_PLAIN;
            end
          end
          SCAN_IGNORE: scan_d = scan_q;
          default:     scan_d = SCAN_BETWEEN;
        endcase
      end
    end
  end

  // actions
  always_comb begin
    do_byte   = 1'b0;
    do_finish = 1'b0;
    do_seed   = 1'b0;
    if (accept_i) begin
      if (is_term) begin
        do_finish = in_tok;
        do_seed   = 1'b1;
      end else if (!is_lead_slash) begin
        unique case (scan_q)
          SCAN_QUOTED: begin
            if (is_quote) do_finish = 1'b1;
            else          do_byte   = 1'b1;
          end
          SCAN_PLAIN: begin
            if (is_sep) do_finish = 1'b1;
            else        do_byte   = 1'b1;
          end
          SCAN_BETWEEN: begin
            if (!is_sep && !lim_hit) begin
              do_seed = 1'b1;
              do_byte = !is_quote;
            end
          end
          SCAN_IGNORE: ;
          default: ;
        endcase
      end
    end
  end

  assign hash_base = do_seed ? HashSeed : hash_q;
  assign hash_step = hash_base + {hash_base[26:0], 5'b0} + 32'(text_byte_i);
  assign tok_after = tok_ext + CW'(do_finish);
  assign do_cmd    = accept_i && is_term && (tok_after != '0);

  always_comb begin
    if (do_byte)                hash_d = hash_step;
    else if (do_seed || do_finish) hash_d = HashSeed;
    else                        hash_d = hash_q;
    tokens_d = (accept_i && is_term) ? '0 : tok_after[TW-1:0];
    start_d  = accept_i ? is_term : start_q;
  end

  always_comb begin
    ev_o.has_byte    = do_byte;
    ev_o.has_tok_end = do_finish;
    ev_o.has_cmd_end = do_cmd;
    ev_o.text        = text_byte_i;
    ev_o.tok_num     = tok_ext[3:0];
    ev_o.hash        = hash_q;
    ev_o.bucket      = hash_q[11:0] & bucket_mask_i & BktLowMask;
    ev_o.count       = tok_after[4:0];
  end

  assign ev_valid_o = do_byte || do_finish || do_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= SCAN_BETWEEN;
      start_q  <= 1'b1;
      tokens_q <= '0;
      hash_q   <= HashSeed;
    end else begin
      scan_q   <= scan_d;
      start_q  <= start_d;
      tokens_q <= tokens_d;
      hash_q   <= hash_d;
    end
  end

endmodule

// File: design/ccl_queue.sv
// ----------------------------------------------------------------------------
// Console command lexer event queue
// Short FIFO of event records between the front end and the back end.
// ----------------------------------------------------------------------------
module ccl_queue import ccl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  ccl_event_t ev_i,
  output logic       full_o,
  input  logic       pop_i,
  output ccl_event_t head_o,
  output logic       empty_o
);

  localparam int unsigned PW = $clog2(QueueDepth);

  ccl_event_t     mem_q [QueueDepth];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= ev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("event pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("event popped from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(QueueDepth))
    else $error("queue count beyond depth");
`endif

endmodule

// File: design/ccl_back.sv
// ----------------------------------------------------------------------------
// Console command lexer back end
// Expands each queued event into one or two result beats.
// ----------------------------------------------------------------------------
module ccl_back import ccl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ccl_event_t  head_i,
  input  logic        empty_i,
  output logic        qpop_o,
  input  logic        pop_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [3:0]  token_number_o,
  output logic [31:0] token_hash_o,
  output logic [11:0] bucket_o,
  output logic [4:0]  count_of_tokens_o,
  output logic        last_o
);

  logic  phase_q, phase_d;
  logic  two, beat;
  kind_e kind;

  assign two  = head_i.has_tok_end && head_i.has_cmd_end;
  assign beat = pop_i && !empty_i;

  always_comb begin
    if (phase_q || (!head_i.has_byte && !head_i.has_tok_end)) kind = KIND_CMD_END;
    else if (head_i.has_byte)                                kind = KIND_BYTE;
    else                                                      kind = KIND_TOK_END;
  end

  always_comb begin
    out_byte_o        = '0;
    token_number_o    = '0;
    token_hash_o      = '0;
    bucket_o          = '0;
    count_of_tokens_o = '0;
    unique case (kind)
      KIND_BYTE: begin
        out_byte_o     = head_i.text;
        token_number_o = head_i.tok_num;
      end
      KIND_TOK_END: begin
        token_number_o = head_i.tok_num;
        token_hash_o   = head_i.hash;
        bucket_o       = head_i.bucket;
      end
      KIND_CMD_END: begin
        count_of_tokens_o = head_i.count;
      end
      default: ;
    endcase
  end

  assign kind_o  = kind;
  assign last_o  = phase_q || !two;
  assign qpop_o  = beat && last_o;
  assign phase_d = beat ? (!phase_q && two) : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (!empty_i && head_i.has_tok_end && head_i.has_cmd_end))
    else $error("second beat without a token end and command end pair");
  a_pair_splits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && !last_o) |=> (phase_q && !empty_i))
    else $error("first beat of a pair not followed by its second");
`endif

endmodule

// File: design/console_command_lexer_unit.sv
// ----------------------------------------------------------------------------
// Console command lexer
// Splits console text into commands and tokens, reporting token bytes, token
// ends with djb2 hash and bucket, and command ends with the token count.
//
//   channel  | handshake         | payload
//   ---------+-------------------+-------------------------------------------
//   input    | push / full       | text_byte_i
//   result   | empty / pop       | kind_o, out_byte_o, token_number_o,
//            |                   | token_hash_o, bucket_o, count_of_tokens_o,
//            |                   | last_o
//   config   | cfg_we_i          | cfg_idx_i, cfg_data_i
//
// One byte is taken per cycle while full is low; its results are written
// to a four-entry event queue and leave it one beat per cycle while pop is
// high. A byte that ends a token and its command gives two beats and holds
// the queue head until both are popped; any other byte gives at most one.
// full is high while the event queue holds four events.
// Reset: between tokens, at command start, token_limit 16, bucket_mask 255.
// ----------------------------------------------------------------------------
module console_command_lexer_unit import ccl_pkg::*; #(
  parameter int unsigned MAX_TOKENS  = MaxTokensDefault,
  parameter int unsigned BUCKET_BITS = BucketBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [3:0]  token_number_o,
  output logic [31:0] token_hash_o,
  output logic [11:0] bucket_o,
  output logic [4:0]  count_of_tokens_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [11:0] cfg_data_i
);

  logic [4:0]  token_limit_q, token_limit_d;
  logic [11:0] bucket_mask_q, bucket_mask_d;

  logic        accept;
  ccl_event_t  ev, head;
  logic        ev_valid, qpop;

  always_comb begin
    token_limit_d = token_limit_q;
    bucket_mask_d = bucket_mask_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TOKEN_LIMIT: token_limit_d = cfg_data_i[4:0];
        CFG_BUCKET_MASK: bucket_mask_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_limit_q <= TokenLimitReset;
      bucket_mask_q <= BucketMaskReset;
    end else begin
      token_limit_q <= token_limit_d;
      bucket_mask_q <= bucket_mask_d;
    end
  end

  assign accept = push && !full;

  ccl_front #(
    .MAX_TOKENS  (MAX_TOKENS),
    .BUCKET_BITS (BUCKET_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (text_byte_i),
    .token_limit_i (token_limit_q),
    .bucket_mask_i (bucket_mask_q),
    .ev_o          (ev),
    .ev_valid_o    (ev_valid)
  );

  ccl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_valid),
    .ev_i    (ev),
    .full_o  (full),
    .pop_i   (qpop),
    .head_o  (head),
    .empty_o (empty)
  );

  ccl_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head),
    .empty_i           (empty),
    .qpop_o            (qpop),
    .pop_i             (pop),
    .kind_o            (kind_o),
    .out_byte_o        (out_byte_o),
    .token_number_o    (token_number_o),
    .token_hash_o      (token_hash_o),
    .bucket_o          (bucket_o),
    .count_of_tokens_o (count_of_tokens_o),
    .last_o            (last_o)
  );

endmodule

// File: bench/console_command_lexer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console command lexer testbench
// Streams console text into the lexer through its push/full side and pops
// beats from the empty/pop side with random bursts of idling on both. Every
// accepted byte is run through a behavioural copy of the lexer held in a
// small scoreboard, and each popped beat is checked field by field against
// the oldest predicted beat. The run starts with a short directed sequence
// and then moves through several register settings with random commands.
// ----------------------------------------------------------------------------
module console_command_lexer_unit_tb;
  import ccl_pkg::*;

  localparam int unsigned RxHoldCycles = 40;
  localparam int unsigned DrainCycles  = 8;
  localparam realtime     TimeoutNs    = 8ms;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  chr;
    logic [3:0]  tok_num;
    logic [31:0] hash;
    logic [11:0] bucket;
    logic [4:0]  count;
    logic        last;
  } lexer_beat_t;

  class lexer_scoreboard;
    scan_e       scan;
    bit          cmd_start;
    logic [4:0]  tok_cnt;
    logic [31:0] hash;
    logic [4:0]  limit_reg;
    logic [11:0] mask_reg;
    lexer_beat_t expected_beats[$];
    int          mismatches;
    int          beats_checked;
    int          useful_bytes;
    int          tokens_seen;
    int          commands_seen;

    function new();
      scan      = SCAN_BETWEEN;
      cmd_start = 1'b1;
      tok_cnt   = '0;
      hash      = HashSeed;
      limit_reg = TokenLimitReset;
      mask_reg  = BucketMaskReset;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function int limit_in_force();
      return (limit_reg > MaxTokensDefault) ? MaxTokensDefault : int'(limit_reg);
    endfunction

    function void set_reg(cfg_reg_e idx, logic [11:0] data);
      if (idx == CFG_TOKEN_LIMIT) limit_reg = data[4:0];
      else mask_reg = data;
    endfunction

    function void add_beat(kind_e k, logic [7:0] c, logic [3:0] n, logic [31:0] h,
                           logic [11:0] bk, logic [4:0] cnt);
      lexer_beat_t b;
      b.kind    = k;
      b.chr     = c;
      b.tok_num = n;
      b.hash    = h;
      b.bucket  = bk;
      b.count   = cnt;
      b.last    = 1'b0;
      expected_beats.push_back(b);
    endfunction

    function void end_token();
      add_beat(KIND_TOK_END, 8'd0, tok_cnt[3:0], hash, hash[11:0] & mask_reg, 5'd0);
      tok_cnt++;
      tokens_seen++;
      hash = HashSeed;
      scan = SCAN_BETWEEN;
    endfunction

    function void add_char(logic [7:0] c);
      hash = hash * 32'd33 + {24'd0, c};
      add_beat(KIND_BYTE, c, tok_cnt[3:0], 32'd0, 12'd0, 5'd0);
    endfunction

    // Predicts the beats caused by one accepted byte.
    function void note_byte(logic [7:0] c);
      int n0;
      bit first;
      n0 = expected_beats.size();
      first = cmd_start;
      cmd_start = 1'b0;
      if (c == ChNul || c == ChNewline || c == ChSemi) begin
        if (scan == SCAN_PLAIN || scan == SCAN_QUOTED) end_token();
        if (tok_cnt != 0) begin
          add_beat(KIND_CMD_END, 8'd0, 4'd0, 32'd0, 12'd0, tok_cnt);
          commands_seen++;
        end
        scan      = SCAN_BETWEEN;
        cmd_start = 1'b1;
        tok_cnt   = '0;
        hash      = HashSeed;
      end else if (first && c == ChSlash) begin
        // leading slash dropped
      end else if (scan == SCAN_IGNORE) begin
        // past the token limit
      end else if (scan == SCAN_QUOTED) begin
        if (c == ChQuote) end_token();
        else add_char(c);
      end else if (scan == SCAN_PLAIN) begin
        if (c <= ChSpace) end_token();
        else add_char(c);
      end else if (c > ChSpace) begin
        if (tok_cnt >= limit_in_force()) begin
          scan = SCAN_IGNORE;
        end else if (c == ChQuote) begin
          hash = HashSeed;
          scan = SCAN_QUOTED;
        end else begin
          hash = HashSeed;
          scan = SCAN_PLAIN;
          add_char(c);
        end
      end
      if (expected_beats.size() > n0) begin
        expected_beats[expected_beats.size() - 1].last = 1'b1;
        useful_bytes++;
      end
    endfunction

    function void report(string what, lexer_beat_t e, lexer_beat_t g);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] %s at beat %0d", $realtime, what, beats_checked);
        $display("  exp kind %0d byte %02h num %0d hash %08h bucket %03h count %0d last %0d",
                 e.kind, e.chr, e.tok_num, e.hash, e.bucket, e.count, e.last);
        $display("  got kind %0d byte %02h num %0d hash %08h bucket %03h count %0d last %0d",
                 g.kind, g.chr, g.tok_num, g.hash, g.bucket, g.count, g.last);
      end
    endfunction

    function void check_beat(lexer_beat_t got);
      lexer_beat_t exp;
      if (expected_beats.size() == 0) begin
        exp = '{default: '0};
        report("unexpected beat", exp, got);
      end else begin
        exp = expected_beats.pop_front();
        if (got.kind !== exp.kind || got.chr !== exp.chr || got.tok_num !== exp.tok_num ||
            got.hash !== exp.hash || got.bucket !== exp.bucket ||
            got.count !== exp.count || got.last !== exp.last)
          report("beat mismatch", exp, got);
      end
      beats_checked++;
    endfunction
  endclass

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        push       = 1'b0;
  logic        full;
  logic [7:0]  text_byte  = 8'd0;
  logic        empty;
  logic        pop        = 1'b0;
  logic [1:0]  res_kind;
  logic [7:0]  res_byte;
  logic [3:0]  res_num;
  logic [31:0] res_hash;
  logic [11:0] res_bucket;
  logic [4:0]  res_count;
  logic        res_last;
  logic        cfg_we     = 1'b0;
  cfg_reg_e    cfg_idx    = CFG_TOKEN_LIMIT;
  logic [11:0] cfg_data   = 12'd0;

  lexer_scoreboard sb;
  lexer_beat_t     popped;
  bit              idling_on   = 1'b1;
  bit              rx_hold_req = 1'b0;
  int              bytes_sent  = 0;
  int              settings    = 1;

  console_command_lexer_unit i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .text_byte_i       (text_byte),
    .empty             (empty),
    .pop               (pop),
    .kind_o            (res_kind),
    .out_byte_o        (res_byte),
    .token_number_o    (res_num),
    .token_hash_o      (res_hash),
    .bucket_o          (res_bucket),
    .count_of_tokens_o (res_count),
    .last_o            (res_last),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutNs);
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) sb.note_byte(text_byte);
      if (pop && !empty) begin
        popped.kind    = res_kind;
        popped.chr     = res_byte;
        popped.tok_num = res_num;
        popped.hash    = res_hash;
        popped.bucket  = res_bucket;
        popped.count   = res_count;
        popped.last    = res_last;
        sb.check_beat(popped);
      end
    end
  end

  // Result side: random pop bursts, plus one long hold-off on request.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        pop <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_byte(input logic [7:0] c);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    push      <= 1'b1;
    text_byte <= c;
    bytes_sent++;
    do @(posedge clk_i); while (full);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [11:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(input logic [4:0] limit, input logic [11:0] mask);
    wait_drained();
    write_reg(CFG_TOKEN_LIMIT, {7'($urandom_range(0, 127)), limit});
    write_reg(CFG_BUCKET_MASK, mask);
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 255)); while (c == ChSemi || c == ChQuote);
    return c;
  endfunction

  function automatic logic [7:0] quoted_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == ChNewline || c == ChSemi || c == ChQuote);
    return c;
  endfunction

  function automatic logic [7:0] sep_char();
    logic [7:0] c;
    c = ChSpace;
    if ($urandom_range(0, 1) == 1) begin
      c = 8'($urandom_range(1, 32));
      if (c == ChNewline) c = ChSpace;
    end
    return c;
  endfunction

  // One command: mostly well formed with random content, some noise.
  task automatic send_command();
    int  ntok;
    int  len;
    bit  quoted;
    bit  prev_quoted;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 7) == 0) send_byte(ChSlash);
    ntok = $urandom_range(0, sb.limit_in_force() + 2);
    prev_quoted = 1'b0;
    for (int i = 0; i < ntok; i++) begin
      repeat ($urandom_range((i == 0 || prev_quoted) ? 0 : 1, 3)) send_byte(sep_char());
      quoted = ($urandom_range(0, 3) == 0);
      len = $urandom_range(quoted ? 0 : 1, 6);
      if (quoted) begin
        send_byte(ChQuote);
        repeat (len) send_byte(quoted_char());
        // unterminated quote only on the final token
        if (i < ntok - 1 || $urandom_range(0, 4) != 0) send_byte(ChQuote);
      end else begin
        send_byte(plain_char());
        repeat (len - 1) send_byte(($urandom_range(0, 9) == 0) ? ChQuote : plain_char());
      end
      if ($urandom_range(0, 15) == 0) send_byte(8'($urandom_range(0, 255)));
      prev_quoted = quoted;
    end
    repeat ($urandom_range(0, 2)) send_byte(sep_char());
    case ($urandom_range(0, 2))
      0: send_byte(ChNul);
      1: send_byte(ChNewline);
      default: send_byte(ChSemi);
    endcase
  endtask

  task automatic run_random(input int target);
    int sent0;
    sent0 = bytes_sent;
    while (bytes_sent - sent0 < target)
      send_command();
  endtask

  // Long receiver hold-off against a steady stream, then a full drain.
  task automatic squeeze_queue();
    bit saved;
    saved = idling_on;
    idling_on = 1'b0;
    send_byte(ChNewline);
    rx_hold_req = 1'b1;
    for (int i = 0; i < 24; i++) send_byte(8'h61 + 8'(i % 26));
    idling_on = saved;
    wait_drained();
  endtask

  initial begin
    logic [7:0] intro [22];
    intro = '{ChSemi, ChSlash, 8'h61, 8'h62, ChQuote, 8'h63, ChSpace,
              ChQuote, ChQuote, ChQuote, 8'h71, ChQuote, 8'h72,
              8'hFF, 8'h80, 8'h21, 8'h01, ChSpace,
              ChQuote, 8'h78, ChNewline, ChNul};
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (intro[i]) send_byte(intro[i]);
    run_random(200);

    configure(5'd1, 12'h000);
    run_random(160);

    configure(5'd16, 12'hFFF);
    run_random(120);
    squeeze_queue();
    run_random(120);

    configure(5'd0, 12'($urandom_range(0, 4095)));
    run_random(50);

    configure(5'd31, 12'($urandom_range(0, 4095)));
    run_random(200);

    repeat (3) begin
      configure(5'($urandom_range(0, 31)), 12'($urandom_range(0, 4095)));
      run_random(160);
    end

    configure(5'($urandom_range(1, 16)), 12'($urandom_range(0, 4095)));
    wait_drained();
    idling_on = 1'b0;
    run_random(160);
    wait_drained();

    $display("Sent %0d bytes (%0d gave beats) over %0d register settings; checked %0d beats.",
             bytes_sent, sb.useful_bytes, settings, sb.beats_checked);
    $display("Tokens ended: %0d, commands ended: %0d, mismatches: %0d.",
             sb.tokens_seen, sb.commands_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/ccl_pkg.sv
design/ccl_front.sv
design/ccl_queue.sv
design/ccl_back.sv
design/console_command_lexer_unit.sv
bench/console_command_lexer_unit_tb.sv
